/* rtl/assert_macros.svh */
// Assertion macros shared by the formatter RTL.
// Expects clk and rst_n (synchronous, active low) in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define ITOA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ITOA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/itoa_pkg.sv */
// Shared types, codes and helper functions of the integer-to-ASCII formatter.
// No dependencies; the controller, datapath and top level import this package.
package itoa_pkg;

  localparam int MAX_PAD_DEF = 32;
  localparam int DEC_DIGITS  = 20;  // digits of the largest 64-bit unsigned value
  localparam int DIG_IW      = $clog2(DEC_DIGITS);
  localparam int NAT_W       = $clog2(DEC_DIGITS + 1);
  localparam int VAL_W       = 64;

  localparam logic [1:0] KIND_UDEC = 2'd0;
  localparam logic [1:0] KIND_SDEC = 2'd1;
  localparam logic [1:0] KIND_HEX  = 2'd2;
  localparam logic [1:0] KIND_BAD  = 2'd3;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CHAR_A_OFS = 8'h57;  // 'a' - 10
  localparam logic [7:0] CHAR_MINUS = 8'h2d;  // '-'
  localparam logic [3:0] DIGIT_TEN  = 4'd10;

  typedef logic [DEC_DIGITS-1:0][3:0] digits_t;

  typedef struct packed {
    logic load;
    logic step;
    logic size;
    logic emit_sign;
    logic emit_digit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic skip;       // input kind is not a conversion
    logic in_hex;     // input kind is hexadecimal
    logic conv_last;  // final double-dabble step
    logic neg;        // minus sign pending
    logic idx_zero;   // current digit is the last one
    logic out_free;   // output register can take a character
  } ctrl_sts_t;

  // One double-dabble step: correct each BCD digit, then shift in one bit.
  function automatic digits_t bcd_shift(digits_t b, logic bit_in);
    logic [3:0]              d;
    digits_t                 t;
    logic [4*DEC_DIGITS-1:0] f;
    for (int i = 0; i < DEC_DIGITS; i++) begin
      d = b[i];
      if (d >= 4'd5) begin
        d = d + 4'd3;
      end
      t[i] = d;
    end
    f = t;
    f = {f[4*DEC_DIGITS-2:0], bit_in};
    return digits_t'(f);
  endfunction

  // Count of significant digits, at least one.
  function automatic logic [NAT_W-1:0] nat_digits(digits_t b);
    logic [NAT_W-1:0] n;
    n = NAT_W'(1);
    for (int i = 0; i < DEC_DIGITS; i++) begin
      if (b[i] != 4'd0) begin
        n = NAT_W'(i + 1);
      end
    end
    return n;
  endfunction

endpackage

/* rtl/itoa_in_if.sv */
// Input channel of the formatter: valid/ready handshake and number payload.
// No dependencies.
interface itoa_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic        is_long;
  logic [63:0] value;
  logic [5:0]  min_width;

  modport source (output valid, kind, is_long, value, min_width, input ready);
  modport sink   (input valid, kind, is_long, value, min_width, output ready);
endinterface

/* rtl/itoa_out_if.sv */
// Result channel of the formatter: one ASCII character per transaction.
// No dependencies.
interface itoa_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last;

  modport source (output valid, char_code, last, input ready);
  modport sink   (input valid, char_code, last, output ready);
endinterface

/* rtl/integer_to_ascii_formatter_unit.sv */
// Top level of the integer-to-ASCII formatter: controller plus datapath.
// Depends on itoa_pkg, itoa_in_if, itoa_out_if, itoa_ctrl and itoa_dp.
//
// Each input transaction carries one integer and a format (unsigned decimal,
// signed decimal or lowercase hex, 32- or 64-bit, minimum digit count); the
// unit answers with its ASCII text, one character per output transaction,
// most significant first, with last set on the final character. A minus
// sign precedes any zero padding, the most negative value prints its full
// magnitude, and the minimum count saturates at MAX_PAD (20..63). An item
// with the unused kind code is taken and produces nothing. One item is in
// flight at a time: after acceptance, decimal conversion runs a double-dabble
// unit two bits per cycle (longer for 64-bit values than for 32-bit ones, not
// at all for hex), sizing follows, and then one character leaves per cycle
// while the sink is ready. The double-dabble loop sets the conversion part of
// the time an item takes and the character count sets the rest.
module integer_to_ascii_formatter_unit #(
  parameter int MAX_PAD = itoa_pkg::MAX_PAD_DEF
) (
  input logic       clk,
  input logic       rst_n,
  itoa_in_if.sink   in_ch,
  itoa_out_if.source out_ch
);
  import itoa_pkg::*;

  ctrl_cmd_t cmd;  // controller commands to the datapath
  ctrl_sts_t sts;  // datapath status back to the controller

  // Sequencer: owns the input handshake and decides when to emit.
  itoa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: holds the payload, converts it and drives the output register.
  itoa_dp #(
    .MAX_PAD (MAX_PAD)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_kind       (in_ch.kind),
    .in_is_long    (in_ch.is_long),
    .in_value      (in_ch.value),
    .in_min_width  (in_ch.min_width),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_char_code (out_ch.char_code),
    .out_last      (out_ch.last),
    .cmd           (cmd),
    .sts           (sts)
  );

endmodule

/* rtl/itoa_ctrl.sv */
// Sequencer of the formatter: load, convert, size, then emit characters.
// Depends on itoa_pkg and assert_macros.svh.
`include "assert_macros.svh"

module itoa_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  itoa_pkg::ctrl_sts_t   sts,
  output itoa_pkg::ctrl_cmd_t   cmd
);
  import itoa_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIZE,
    ST_SIGN,
    ST_DIGITS
  } state_t;

  state_t state_r;
  logic   in_ready_r;
  logic   accept;

  assign in_ready = in_ready_r;
  assign accept   = in_valid && in_ready_r;

  always_comb begin
    cmd            = '0;
    cmd.load       = accept;
    cmd.step       = (state_r == ST_CONV);
    cmd.size       = (state_r == ST_SIZE);
    cmd.emit_sign  = (state_r == ST_SIGN) && sts.out_free;
    cmd.emit_digit = (state_r == ST_DIGITS) && sts.out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      in_ready_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (accept && !sts.skip) begin
            in_ready_r <= 1'b0;
            state_r    <= sts.in_hex ? ST_SIZE : ST_CONV;
          end else begin
            in_ready_r <= 1'b1;
          end
        end
        ST_CONV: begin
          if (sts.conv_last) begin
            state_r <= ST_SIZE;
          end
        end
        ST_SIZE: begin
          state_r <= sts.neg ? ST_SIGN : ST_DIGITS;
        end
        ST_SIGN: begin
          if (sts.out_free) begin
            state_r <= ST_DIGITS;
          end
        end
        ST_DIGITS: begin
          if (sts.out_free && sts.idx_zero) begin
            state_r    <= ST_IDLE;
            in_ready_r <= 1'b1;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  `ITOA_ASSERT_IMPL(a_emit_needs_slot, cmd.emit_sign || cmd.emit_digit, sts.out_free, "emit into occupied output")
  `ITOA_ASSERT_NEXT(a_last_digit_idle, state_r == ST_DIGITS && sts.out_free && sts.idx_zero, state_r == ST_IDLE && in_ready_r, "no return to idle after last digit")

endmodule

/* rtl/itoa_dp.sv */
// Datapath of the formatter: magnitude, double-dabble converter, digit
// store, index counter and output register. Depends on itoa_pkg, assert_macros.svh.
`include "assert_macros.svh"

module itoa_dp #(
  parameter int MAX_PAD = itoa_pkg::MAX_PAD_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [1:0]            in_kind,
  input  logic                  in_is_long,
  input  logic [63:0]           in_value,
  input  logic [5:0]            in_min_width,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_char_code,
  output logic                  out_last,
  input  itoa_pkg::ctrl_cmd_t   cmd,
  output itoa_pkg::ctrl_sts_t   sts
);
  import itoa_pkg::*;

  localparam int TOT_MAX = (MAX_PAD > DEC_DIGITS) ? MAX_PAD : DEC_DIGITS;
  localparam int TOT_W   = $clog2(TOT_MAX + 1);
  localparam int IDX_W   = $clog2(TOT_MAX);

  logic [VAL_W-1:0] v_ext, mag, mag_r;
  logic             neg, neg_r, hex_r;
  logic [TOT_W-1:0] pad, pad_r, total;
  logic [NAT_W-1:0] nat;
  logic [4:0]       cnt_r;
  logic [IDX_W-1:0] idx_r;
  digits_t          dig_r;
  logic [3:0]       digit;
  logic [7:0]       char_code;
  logic             out_valid_r, out_last_r;
  logic [7:0]       out_char_r;

  // Operand preparation: width cut, sign extension, magnitude.
  always_comb begin
    v_ext = in_is_long ? in_value
                       : {{32{(in_kind == KIND_SDEC) && in_value[31]}}, in_value[31:0]};
    neg   = (in_kind == KIND_SDEC) && v_ext[VAL_W-1];
    mag   = neg ? (VAL_W'(0) - v_ext) : v_ext;
    if (in_min_width == 6'd0) begin
      pad = TOT_W'(1);
    end else if (int'(in_min_width) > MAX_PAD) begin
      pad = TOT_W'(MAX_PAD);
    end else begin
      pad = TOT_W'(in_min_width);
    end
  end

  always_comb begin
    nat   = nat_digits(dig_r);
    total = (TOT_W'(nat) > pad_r) ? TOT_W'(nat) : pad_r;
    digit = (int'(idx_r) < DEC_DIGITS) ? dig_r[idx_r[DIG_IW-1:0]] : 4'd0;
    if (hex_r && (digit >= DIGIT_TEN)) begin
      char_code = CHAR_A_OFS + {4'd0, digit};
    end else begin
      char_code = CHAR_ZERO + {4'd0, digit};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hex_r <= (in_kind == KIND_HEX);
      neg_r <= neg;
      pad_r <= pad;
      mag_r <= in_is_long ? mag : {mag[31:0], 32'd0};
      dig_r <= (in_kind == KIND_HEX) ? digits_t'({16'd0, mag}) : '0;
    end else if (cmd.step) begin
      dig_r <= bcd_shift(bcd_shift(dig_r, mag_r[VAL_W-1]), mag_r[VAL_W-2]);
      mag_r <= {mag_r[VAL_W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Hold the step count at zero once the last step is taken.
      if (cmd.load) begin
        cnt_r <= in_is_long ? 5'd31 : 5'd15;
      end else if (cmd.step && (cnt_r != 5'd0)) begin
        cnt_r <= cnt_r - 5'd1;
      end
      if (cmd.size) begin
        idx_r <= IDX_W'(total - TOT_W'(1));
      end else if (cmd.emit_digit) begin
        idx_r <= idx_r - IDX_W'(1);
      end
      if (cmd.emit_sign || cmd.emit_digit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      out_char_r <= CHAR_MINUS;
      out_last_r <= 1'b0;
    end else if (cmd.emit_digit) begin
      out_char_r <= char_code;
      out_last_r <= (idx_r == '0);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_r;
  assign out_last      = out_last_r;

  always_comb begin
    sts           = '0;
    sts.skip      = (in_kind == KIND_BAD);
    sts.in_hex    = (in_kind == KIND_HEX);
    sts.conv_last = (cnt_r == 5'd0);
    sts.neg       = neg_r;
    sts.idx_zero  = (idx_r == '0);
    sts.out_free  = !out_valid_r || out_ready;
  end

  `ITOA_ASSERT_IMPL(a_size_after_conv, cmd.size, hex_r || cnt_r == 5'd0, "sizing before conversion done")
  `ITOA_ASSERT_IMPL(a_neg_not_hex, cmd.size && neg_r, !hex_r, "minus sign on hexadecimal item")

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for integer_to_ascii_formatter_unit: directed table, then random numbers.
// Depends on itoa_pkg, itoa_in_if, itoa_out_if and the formatter RTL; needs no files at run time.
module tb_top;
  import itoa_pkg::*;

  localparam int MAX_PAD        = 32;
  localparam int TEXT_MAX       = 64;    // character buffer bound of the text model
  localparam int RANDOM_ITEMS   = 75;    // convertible items in the random part
  localparam int DRAIN_CYCLES   = 80;    // longer than one 64-bit signed conversion
  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no transaction on either side

  // One number to format. Where typed is set, text holds the exact expected string
  // (empty for the unused kind); otherwise the expectation comes from format_text.
  typedef struct {
    logic [1:0]  kind;
    logic        is_long;
    logic [63:0] value;
    logic [5:0]  min_width;
    bit          typed;
    string       text;
  } num_row_t;

  typedef struct packed {
    logic [7:0] code;
    logic       is_last;
  } text_char_t;

  logic clk;
  logic rst_n;

  itoa_in_if  in_ch ();
  itoa_out_if out_ch ();

  integer_to_ascii_formatter_unit #(
    .MAX_PAD (MAX_PAD)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  num_row_t   stim_rows[$];      // numbers not yet offered
  num_row_t   offered_rows[$];   // numbers driven, waiting for their input transaction
  text_char_t expected_chars[$]; // characters still owed by the formatter
  int         fail_count = 0;
  int         idle_cycles;
  bit         src_calm;          // sender runs back to back while set
  bit         sink_calm;         // receiver starts no new stall while set
  int         stall_left;
  int         sink_cycles;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Append the characters that one number formats to.
  function automatic void format_text(num_row_t row);
    logic [63:0] mag;
    logic [3:0]  nib;
    logic [7:0]  digs[TEXT_MAX];
    bit          neg;
    int          pad;
    int          n;
    pad = (row.min_width == 6'd0) ? 1 : int'(row.min_width);
    if (pad > MAX_PAD) begin
      pad = MAX_PAD;
    end
    if (row.kind == KIND_BAD) begin
      return;
    end
    mag = row.value;
    neg = 1'b0;
    // 32-bit mode: drop the upper word, sign-extend signed values from bit 31
    if (!row.is_long) begin
      mag = {32'd0, row.value[31:0]};
      if (row.kind == KIND_SDEC && row.value[31]) begin
        mag[63:32] = '1;
      end
    end
    if (row.kind == KIND_SDEC && mag[63]) begin
      neg = 1'b1;
      mag = -mag;
    end
    n = 0;
    do begin
      if (row.kind == KIND_HEX) begin
        nib = mag[3:0];
        mag = mag >> 4;
        digs[n] = (nib < DIGIT_TEN) ? CHAR_ZERO + 8'(nib) : CHAR_A_OFS + 8'(nib);
      end else begin
        digs[n] = CHAR_ZERO + 8'(mag % 64'(DIGIT_TEN));
        mag = mag / 64'(DIGIT_TEN);
      end
      n++;
    end while (mag != 64'd0 && n < TEXT_MAX);
    while (n < pad && n < TEXT_MAX) begin
      digs[n] = CHAR_ZERO;
      n++;
    end
    if (neg) begin
      expected_chars.push_back('{code: CHAR_MINUS, is_last: 1'b0});
    end
    for (int i = n; i > 0; i--) begin
      expected_chars.push_back('{code: digs[i-1], is_last: (i == 1)});
    end
  endfunction

  // Append a typed-in string, marking its final character.
  function automatic void queue_typed_text(string text);
    for (int i = 0; i < text.len(); i++) begin
      expected_chars.push_back('{code: 8'(text[i]), is_last: (i == text.len() - 1)});
    end
  endfunction

  function automatic void add_row(logic [1:0] kind, logic is_long, logic [63:0] value,
                                  logic [5:0] min_width, bit typed, string text);
    num_row_t row;
    row.kind      = kind;
    row.is_long   = is_long;
    row.value     = value;
    row.min_width = min_width;
    row.typed     = typed;
    row.text      = text;
    stim_rows.push_back(row);
  endfunction

  // Random number: mostly convertible kinds, values shaped to hit short and long texts,
  // sign boundaries and padding, with the full 64 bits and all six pad bits exercised.
  function automatic num_row_t random_row();
    num_row_t row;
    int       pick;
    pick = $urandom_range(0, 99);
    row.kind    = (pick < 5) ? KIND_BAD : 2'($urandom_range(0, 2));
    row.is_long = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 5))
      0: row.value = {$urandom, $urandom};
      1: row.value = 64'($urandom_range(0, 999));
      2: row.value = -64'($urandom_range(1, 1000));
      3: row.value = {$urandom, 1'b1, 31'($urandom)};
      4: row.value = 64'd1 << $urandom_range(0, 63);
      default: row.value = {$urandom, $urandom} >> $urandom_range(0, 63);
    endcase
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      row.min_width = 6'($urandom_range(0, 12));
    end else if (pick < 85) begin
      row.min_width = 6'($urandom_range(13, 25));
    end else begin
      row.min_width = 6'($urandom_range(0, 63));
    end
    row.typed = 1'b0;
    row.text  = "";
    return row;
  endfunction

  // Sender gap: mostly none, some short, a few long; none during a calm stretch.
  function automatic int pick_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (src_calm || pick < 60) begin
      return 0;
    end
    return (pick < 90) ? $urandom_range(1, 3) : $urandom_range(8, 30);
  endfunction

  // Receiver: stall at random with short and long stalls; in calm stretches hold ready high once a stall ends.
  always @(posedge clk) begin : sink_ready_gen
    int pick;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left   <= 0;
      sink_cycles  <= 0;
      sink_calm    <= 1'b0;
    end else begin
      sink_cycles <= sink_cycles + 1;
      if (sink_cycles % 256 == 255) begin
        sink_calm <= ($urandom_range(0, 3) == 0);
      end
      pick = $urandom_range(0, 99);
      if (stall_left != 0) begin
        out_ch.ready <= 1'b0;
        stall_left   <= stall_left - 1;
      end else if (sink_calm || pick < 65) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b0;
        stall_left   <= (pick < 92) ? $urandom_range(0, 2) : $urandom_range(9, 29);
      end
    end
  end

  // Check each output transaction against the oldest owed character, then
  // queue the text of any number accepted at this same edge. Doing both in one
  // process keeps the queue order independent of event scheduling.
  always @(posedge clk) begin : text_scoreboard
    text_char_t want;
    num_row_t   row;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_chars.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected character: expected none, actual char_code %h last %b",
                   $time, out_ch.char_code, out_ch.last);
        end else begin
          want = expected_chars.pop_front();
          if (out_ch.char_code !== want.code) begin
            fail_count++;
            $display("%0t: char_code mismatch: expected %h, actual %h",
                     $time, want.code, out_ch.char_code);
          end
          if (out_ch.last !== want.is_last) begin
            fail_count++;
            $display("%0t: last mismatch: expected %b, actual %b",
                     $time, want.is_last, out_ch.last);
          end
        end
      end
      if (in_ch.valid && in_ch.ready && offered_rows.size() != 0) begin
        row = offered_rows.pop_front();
        if (row.typed) begin
          queue_typed_text(row.text);
        end else begin
          format_text(row);
        end
      end
    end
  end

  // Abort when neither channel moves a transaction for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    num_row_t row;
    int       gap;
    int       sent;
    int       useful;
    int       n_directed;
    src_calm           = 1'b0;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.kind        <= KIND_UDEC;
    in_ch.is_long     <= 1'b0;
    in_ch.value       <= '0;
    in_ch.min_width   <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table: zero and padding, width extremes, most negative values,
    // the unused kind, saturated minimum, natural length over the minimum.
    add_row(KIND_UDEC, 1'b0, 64'd0,                    6'd0,  1, "0");
    add_row(KIND_UDEC, 1'b0, 64'd0,                    6'd1,  1, "0");
    add_row(KIND_UDEC, 1'b0, 64'h0000_0000_ffff_ffff,  6'd0,  1, "4294967295");
    add_row(KIND_UDEC, 1'b0, 64'hffff_ffff_ffff_ffff,  6'd0,  1, "4294967295");
    add_row(KIND_UDEC, 1'b1, 64'hffff_ffff_ffff_ffff,  6'd0,  1, "18446744073709551615");
    add_row(KIND_SDEC, 1'b0, 64'h0000_0000_8000_0000,  6'd0,  1, "-2147483648");
    add_row(KIND_SDEC, 1'b1, 64'h8000_0000_0000_0000,  6'd0,  1, "-9223372036854775808");
    add_row(KIND_SDEC, 1'b0, 64'h0000_0000_ffff_ffff,  6'd0,  1, "-1");
    add_row(KIND_SDEC, 1'b1, 64'hffff_ffff_ffff_ffff,  6'd5,  1, "-00001");
    add_row(KIND_SDEC, 1'b0, 64'h0000_0000_7fff_ffff,  6'd0,  1, "2147483647");
    add_row(KIND_SDEC, 1'b1, 64'h7fff_ffff_ffff_ffff,  6'd0,  1, "9223372036854775807");
    add_row(KIND_SDEC, 1'b0, 64'hffff_ffff_0000_0005,  6'd0,  1, "5");
    add_row(KIND_HEX,  1'b0, 64'hdead_beef_cafe_babe,  6'd0,  1, "cafebabe");
    add_row(KIND_HEX,  1'b1, 64'hdead_beef_cafe_babe,  6'd0,  1, "deadbeefcafebabe");
    add_row(KIND_HEX,  1'b1, 64'hffff_ffff_ffff_ffff,  6'd0,  1, "ffffffffffffffff");
    add_row(KIND_HEX,  1'b0, 64'd0,                    6'd8,  1, "00000000");
    add_row(KIND_HEX,  1'b0, 64'h0000_0000_0000_000a,  6'd0,  1, "a");
    add_row(KIND_BAD,  1'b0, 64'd42,                   6'd3,  1, "");
    add_row(KIND_BAD,  1'b1, 64'hffff_ffff_ffff_ffff,  6'd63, 1, "");
    add_row(KIND_UDEC, 1'b1, 64'd123456789,            6'd3,  1, "123456789");
    add_row(KIND_UDEC, 1'b1, 64'h8ac7_2304_89e8_0000,  6'd0,  1, "10000000000000000000");
    add_row(KIND_UDEC, 1'b0, 64'd7,                    6'd63, 0, "");
    add_row(KIND_SDEC, 1'b1, 64'hffff_ffff_ffff_ffff,  6'd63, 0, "");
    add_row(KIND_HEX,  1'b1, 64'd1,                    6'd40, 0, "");
    add_row(KIND_SDEC, 1'b1, 64'h8000_0000_0000_0000,  6'd33, 0, "");
    n_directed = stim_rows.size();

    // Count only convertible numbers toward the random quota.
    useful = 0;
    while (useful < RANDOM_ITEMS) begin
      row = random_row();
      if (row.kind != KIND_BAD) begin
        useful++;
      end
      stim_rows.push_back(row);
    end

    sent = 0;
    while (stim_rows.size() != 0) begin
      row = stim_rows.pop_front();
      if (sent % 20 == 0) begin
        src_calm = ($urandom_range(0, 2) == 0);
      end
      // Hold off after the directed rows and midway through the random part
      // until every owed character has come out.
      if (sent == n_directed || sent == n_directed + RANDOM_ITEMS / 2) begin
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (expected_chars.size() != 0);
      end else begin
        gap = pick_gap();
        if (gap != 0) begin
          in_ch.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      in_ch.valid     <= 1'b1;
      in_ch.kind      <= row.kind;
      in_ch.is_long   <= row.is_long;
      in_ch.value     <= row.value;
      in_ch.min_width <= row.min_width;
      offered_rows.push_back(row);
      do @(posedge clk); while (!in_ch.ready);
      sent++;
    end
    in_ch.valid <= 1'b0;

    // Drain owed characters, then give an unused-kind item time to retire.
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/itoa_pkg.sv
rtl/itoa_in_if.sv
rtl/itoa_out_if.sv
rtl/itoa_ctrl.sv
rtl/itoa_dp.sv
rtl/integer_to_ascii_formatter_unit.sv
tb/sv/tb_top.sv
